FILE: rtl/core/constant_fold_evaluator_macros.svh
// Assertion macros used by the constant fold evaluator top-level RTL.
// Needs signals named clk and arst_n in the including module.
`ifndef CONSTANT_FOLD_EVALUATOR_MACROS_SVH
`define CONSTANT_FOLD_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cfe_pkg.sv
// Package for the constant fold evaluator: opcode and action codes and the
// control struct carried down the pipeline. No dependencies.
package cfe_pkg;

	localparam int OP_W  = 5;
	localparam int ACT_W = 2;

	localparam logic [OP_W-1:0] OP_BNOT = 5'd0;
	localparam logic [OP_W-1:0] OP_NEG  = 5'd1;
	localparam logic [OP_W-1:0] OP_LNOT = 5'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 5'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 5'd4;
	localparam logic [OP_W-1:0] OP_REM  = 5'd5;
	localparam logic [OP_W-1:0] OP_ADD  = 5'd6;
	localparam logic [OP_W-1:0] OP_SUB  = 5'd7;
	localparam logic [OP_W-1:0] OP_LT   = 5'd8;
	localparam logic [OP_W-1:0] OP_LE   = 5'd9;
	localparam logic [OP_W-1:0] OP_GT   = 5'd10;
	localparam logic [OP_W-1:0] OP_GE   = 5'd11;
	localparam logic [OP_W-1:0] OP_EQ   = 5'd12;
	localparam logic [OP_W-1:0] OP_NE   = 5'd13;
	localparam logic [OP_W-1:0] OP_LAND = 5'd14;
	localparam logic [OP_W-1:0] OP_LOR  = 5'd15;
	localparam logic [OP_W-1:0] OP_JZ   = 5'd16;
	localparam logic [OP_W-1:0] OP_JNZ  = 5'd17;

	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_COPY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_JUMP  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_ERASE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ca;
		logic            cb;
		logic            neg_a;
		logic            neg_b;
	} ctl_t;

endpackage

FILE: rtl/core/cfe_iter.sv
// One step of the iterative datapath: a restoring divide step on the operand
// magnitudes and a shift-and-add multiply step. Depends on cfe_pkg.
module cfe_iter import cfe_pkg::*; #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  ctl_t         in_ctl,
	input  logic [W-1:0] in_a,
	input  logic [W-1:0] in_b,
	input  logic [W-1:0] in_dvd,
	input  logic [W-1:0] in_dsr,
	input  logic [W-1:0] in_rem,
	input  logic [W-1:0] in_quo,
	input  logic [W-1:0] in_mcand,
	input  logic [W-1:0] in_mplier,
	input  logic [W-1:0] in_prod,
	output logic         valid_s2,
	output ctl_t         ctl_s2,
	output logic [W-1:0] a_s2,
	output logic [W-1:0] b_s2,
	output logic [W-1:0] dvd_s2,
	output logic [W-1:0] dsr_s2,
	output logic [W-1:0] rem_s2,
	output logic [W-1:0] quo_s2,
	output logic [W-1:0] mcand_s2,
	output logic [W-1:0] mplier_s2,
	output logic [W-1:0] prod_s2
);

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         fits;
	logic [W-1:0] rem_n;

	// Bring down the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial = {in_rem, in_dvd[W-1]};
		diff  = trial - {1'b0, in_dsr};
		fits  = (trial >= {1'b0, in_dsr});
		rem_n = fits ? diff[W-1:0] : trial[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2    <= in_ctl;
			a_s2      <= in_a;
			b_s2      <= in_b;
			dsr_s2    <= in_dsr;
			dvd_s2    <= in_dvd << 1;
			rem_s2    <= rem_n;
			quo_s2    <= {in_quo[W-2:0], fits};
			prod_s2   <= in_prod + (in_mplier[0] ? in_mcand : '0);
			mcand_s2  <= in_mcand << 1;
			mplier_s2 <= in_mplier >> 1;
		end
	end

endmodule

FILE: rtl/core/cfe_finish.sv
// Final stage: fold decision, unary, logical and compare ops, product, add,
// subtract and quotient and remainder sign fix-up, registered. Depends on cfe_pkg.
module cfe_finish import cfe_pkg::*; #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  ctl_t             in_ctl,
	input  logic [W-1:0]     in_a,
	input  logic [W-1:0]     in_b,
	input  logic [W-1:0]     in_quo,
	input  logic [W-1:0]     in_rem,
	input  logic [W-1:0]     in_prod,
	output logic             valid_s3,
	output logic [ACT_W-1:0] action_s3,
	output logic [W-1:0]     value_s3
);

	logic [ACT_W-1:0] act;
	logic [W-1:0]     val;
	logic             both;

	always_comb begin
		act  = ACT_NONE;
		val  = '0;
		both = in_ctl.ca && in_ctl.cb;
		unique case (in_ctl.op)
			OP_BNOT: if (in_ctl.ca) begin act = ACT_COPY; val = ~in_a; end
			OP_NEG:  if (in_ctl.ca) begin act = ACT_COPY; val = '0 - in_a; end
			OP_LNOT: if (in_ctl.ca) begin act = ACT_COPY; val = W'(in_a == '0); end
			OP_MUL:  if (both) begin act = ACT_COPY; val = in_prod; end
			OP_DIV: if (both && in_b != '0) begin
				act = ACT_COPY;
				val = (in_ctl.neg_a ^ in_ctl.neg_b) ? '0 - in_quo : in_quo;
			end
			OP_REM: if (both && in_b != '0) begin
				act = ACT_COPY;
				val = in_ctl.neg_a ? '0 - in_rem : in_rem;
			end
			OP_ADD:  if (both) begin act = ACT_COPY; val = in_a + in_b; end
			OP_SUB:  if (both) begin act = ACT_COPY; val = in_a - in_b; end
			OP_LT:   if (both) begin act = ACT_COPY; val = W'($signed(in_a) < $signed(in_b)); end
			OP_LE:   if (both) begin act = ACT_COPY; val = W'($signed(in_a) <= $signed(in_b)); end
			OP_GT:   if (both) begin act = ACT_COPY; val = W'($signed(in_a) > $signed(in_b)); end
			OP_GE:   if (both) begin act = ACT_COPY; val = W'($signed(in_a) >= $signed(in_b)); end
			OP_EQ:   if (both) begin act = ACT_COPY; val = W'(in_a == in_b); end
			OP_NE:   if (both) begin act = ACT_COPY; val = W'(in_a != in_b); end
			OP_LAND: if (both) begin
				act = ACT_COPY;
				val = W'((in_a != '0) && (in_b != '0));
			end
			OP_LOR:  if (both) begin
				act = ACT_COPY;
				val = W'((in_a != '0) || (in_b != '0));
			end
			OP_JZ:   if (in_ctl.ca) act = (in_a == '0) ? ACT_JUMP : ACT_ERASE;
			OP_JNZ:  if (in_ctl.ca) act = (in_a != '0) ? ACT_JUMP : ACT_ERASE;
			default: act = ACT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s3 <= act;
			value_s3  <= val;
		end
	end

endmodule

FILE: rtl/core/constant_fold_evaluator.sv
// Constant fold evaluator: one IR instruction item in, one fold result out.
// Pipeline: input register, DATA_WIDTH divide and multiply steps,
// output register. Throughput: one item per cycle while the output moves;
// the chain of one-bit divide steps sets depth.
// Reset: arst_n clears every valid bit at once; payload registers keep data.
// Depends on cfe_pkg, cfe_iter, cfe_finish and the assertion macro header.
`include "constant_fold_evaluator_macros.svh"

module constant_fold_evaluator import cfe_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// first_value, second_value, zero padding to whole bytes
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	// op, first_is_constant, second_is_constant
	input  logic [6:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// folded_value, zero padding to whole bytes
	output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// action
	output logic [ACT_W-1:0]       m_tuser
);

	localparam int W      = DATA_WIDTH;
	localparam int OUT_DW = ((DATA_WIDTH + 7) / 8) * 8;

	// The whole pipeline advances together; it holds only when the output
	// register has an item that the sink is not taking. This way a stall
	// neither drops nor duplicates an item, and a new item can enter in every
	// cycle that the output moves.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Input stage: unpack the item and form the operand magnitudes used by
	// the divider.
	logic [W-1:0] a_in;
	logic [W-1:0] b_in;
	ctl_t         ctl_in;

	always_comb begin
		a_in         = s_tdata[W-1:0];
		b_in         = s_tdata[2*W-1:W];
		ctl_in.op    = s_tuser[OP_W-1:0];
		ctl_in.ca    = s_tuser[OP_W];
		ctl_in.cb    = s_tuser[OP_W+1];
		ctl_in.neg_a = a_in[W-1];
		ctl_in.neg_b = b_in[W-1];
	end

	logic         valid_s1;
	ctl_t         ctl_s1;
	logic [W-1:0] a_s1;
	logic [W-1:0] b_s1;
	logic [W-1:0] ma_s1;
	logic [W-1:0] mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			a_s1   <= a_in;
			b_s1   <= b_in;
			ma_s1  <= a_in[W-1] ? '0 - a_in : a_in;
			mb_s1  <= b_in[W-1] ? '0 - b_in : b_in;
		end
	end

	// Step chain: entry k of each array feeds step k, entry k+1 is its output.
	// Each step retires one quotient bit (most significant first) and one
	// multiplier bit (least significant first).
	logic         ch_valid  [0:W];
	ctl_t         ch_ctl    [0:W];
	logic [W-1:0] ch_a      [0:W];
	logic [W-1:0] ch_b      [0:W];
	logic [W-1:0] ch_dvd    [0:W];
	logic [W-1:0] ch_dsr    [0:W];
	logic [W-1:0] ch_rem    [0:W];
	logic [W-1:0] ch_quo    [0:W];
	logic [W-1:0] ch_mcand  [0:W];
	logic [W-1:0] ch_mplier [0:W];
	logic [W-1:0] ch_prod   [0:W];

	assign ch_valid[0]  = valid_s1;
	assign ch_ctl[0]    = ctl_s1;
	assign ch_a[0]      = a_s1;
	assign ch_b[0]      = b_s1;
	assign ch_dvd[0]    = ma_s1;
	assign ch_dsr[0]    = mb_s1;
	assign ch_rem[0]    = '0;
	assign ch_quo[0]    = '0;
	assign ch_mcand[0]  = a_s1;
	assign ch_mplier[0] = b_s1;
	assign ch_prod[0]   = '0;

	for (genvar k = 0; k < W; k++) begin : g_step
		cfe_iter #(.W(W)) u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (ch_valid[k]),
			.in_ctl    (ch_ctl[k]),
			.in_a      (ch_a[k]),
			.in_b      (ch_b[k]),
			.in_dvd    (ch_dvd[k]),
			.in_dsr    (ch_dsr[k]),
			.in_rem    (ch_rem[k]),
			.in_quo    (ch_quo[k]),
			.in_mcand  (ch_mcand[k]),
			.in_mplier (ch_mplier[k]),
			.in_prod   (ch_prod[k]),
			.valid_s2  (ch_valid[k+1]),
			.ctl_s2    (ch_ctl[k+1]),
			.a_s2      (ch_a[k+1]),
			.b_s2      (ch_b[k+1]),
			.dvd_s2    (ch_dvd[k+1]),
			.dsr_s2    (ch_dsr[k+1]),
			.rem_s2    (ch_rem[k+1]),
			.quo_s2    (ch_quo[k+1]),
			.mcand_s2  (ch_mcand[k+1]),
			.mplier_s2 (ch_mplier[k+1]),
			.prod_s2   (ch_prod[k+1])
		);
	end

	// Output stage: the fold decision and the final arithmetic. The most
	// negative value divided by minus one comes out as itself with remainder
	// zero, since its magnitude negates back to the same bit pattern.
	logic [W-1:0] value_s3;

	cfe_finish #(.W(W)) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ch_valid[W]),
		.in_ctl    (ch_ctl[W]),
		.in_a      (ch_a[W]),
		.in_b      (ch_b[W]),
		.in_quo    (ch_quo[W]),
		.in_rem    (ch_rem[W]),
		.in_prod   (ch_prod[W]),
		.valid_s3  (m_tvalid),
		.action_s3 (m_tuser),
		.value_s3  (value_s3)
	);

	assign m_tdata = OUT_DW'(value_s3);

	// A result that is not a copy always carries a zero value.
	`CFE_ASSERT_NOW(a_zero_unless_copy, m_tvalid && m_tuser != ACT_COPY, value_s3 == '0, "value set without copy")
	// A held output item keeps its payload while the sink stalls.
	`CFE_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed under stall")
	// The first pipeline stage does not move while the output is stalled.
	`CFE_ASSERT_NEXT(a_s1_frozen, m_tvalid && !m_tready, $stable(valid_s1), "pipeline moved under stall")

endmodule
